### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

### sv/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants of the JSON string unescaper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  localparam logic [1:0] TAIL_NONE = 2'd0;
  localparam logic [1:0] TAIL_BYTE = 2'd1;
  localparam logic [1:0] TAIL_CP   = 2'd2;

  localparam logic [7:0]  CH_BSLASH = 8'h5C;
  localparam logic [7:0]  CH_U      = 8'h75;
  localparam logic [20:0] CP_REPL   = 21'h00FFFD;

  localparam int unsigned IDX_W = 4;

  // One token: optional U+FFFD, replay of held "\u" and digits, then a tail.
  typedef struct packed {
    logic        pre_repl;
    logic [2:0]  rep_len;
    logic [1:0]  tail_kind;
    logic [20:0] tail_val;
    logic [7:0]  dig0;
    logic [7:0]  dig1;
    logic [7:0]  dig2;
    logic        last;
  } jsu_tok_t;

endpackage

`default_nettype wire

### sv/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Escape parser: takes one raw byte per item and emits at most one output token.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module jsu_front (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  [7:0]         in_byte,
  input  wire                in_last,
  input  wire                q_full,
  output logic               push,
  output jsu_pkg::jsu_tok_t  tok
);
  import jsu_pkg::*;

  localparam logic [2:0] PH_PLAIN = 3'd0;
  localparam logic [2:0] PH_BS    = 3'd1;
  localparam logic [2:0] PH_U     = 3'd2;
  localparam logic [2:0] PH_HI    = 3'd3;
  localparam logic [2:0] PH_HI_BS = 3'd4;
  localparam logic [2:0] PH_HI_U  = 3'd5;

  function automatic logic hex_ok(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    return (c <= 8'h39) ? c[3:0] : (c[3:0] + 4'd9);
  endfunction

  logic [2:0]  ph_r, ph_nxt;
  logic [1:0]  k_r, k_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [15:0] hi_r, hi_nxt;
  logic [7:0]  dig0_r, dig1_r, dig2_r;
  logic [7:0]  dig0_nxt, dig1_nxt, dig2_nxt;

  logic        is_hex;
  logic [15:0] v_full;
  logic        v_hi, v_lo;
  logic [20:0] pair_cp;
  logic        esc_hit;
  logic [7:0]  esc_val;
  logic        fresh;
  logic        accept;
  jsu_tok_t    t;

  assign is_hex  = hex_ok(in_byte);
  assign v_full  = {acc_r[11:0], hex_val(in_byte)};
  assign v_hi    = (v_full >= 16'hD800) && (v_full <= 16'hDBFF);
  assign v_lo    = (v_full >= 16'hDC00) && (v_full <= 16'hDFFF);
  assign pair_cp = {1'b0, hi_r[9:0], v_full[9:0]} + 21'h010000;
  assign accept  = in_valid && in_ready;
  assign in_ready = !q_full;

  always_comb begin
    esc_hit = 1'b1;
    case (in_byte)
      8'h2F:   esc_val = 8'h2F;
      8'h62:   esc_val = 8'h08;
      8'h66:   esc_val = 8'h0C;
      8'h6E:   esc_val = 8'h0A;
      8'h72:   esc_val = 8'h0D;
      8'h74:   esc_val = 8'h09;
      8'h22:   esc_val = 8'h22;
      8'h5C:   esc_val = 8'h5C;
      default: begin
        esc_hit = 1'b0;
        esc_val = 8'h00;
      end
    endcase
  end

  always_comb begin
    ph_nxt   = ph_r;
    k_nxt    = k_r;
    acc_nxt  = acc_r;
    hi_nxt   = hi_r;
    dig0_nxt = dig0_r;
    dig1_nxt = dig1_r;
    dig2_nxt = dig2_r;
    fresh    = 1'b0;
    t        = '0;
    t.dig0   = dig0_r;
    t.dig1   = dig1_r;
    t.dig2   = dig2_r;
    t.last   = in_last;
    case (ph_r)
      PH_PLAIN: fresh = 1'b1;
      PH_BS, PH_HI_BS: begin
        t.pre_repl = (ph_r == PH_HI_BS);
        if (in_byte == CH_U) begin
          if (in_last) begin
            t.rep_len = 3'd2;
            ph_nxt    = PH_PLAIN;
          end else begin
            t.pre_repl = 1'b0;
            ph_nxt  = (ph_r == PH_HI_BS) ? PH_HI_U : PH_U;
            k_nxt   = 2'd0;
            acc_nxt = 16'd0;
          end
        end else if (esc_hit) begin
          t.tail_kind = TAIL_BYTE;
          t.tail_val  = {13'd0, esc_val};
          ph_nxt      = PH_PLAIN;
        end else begin
          t.rep_len   = 3'd1;
          t.tail_kind = TAIL_BYTE;
          t.tail_val  = {13'd0, in_byte};
          ph_nxt      = PH_PLAIN;
        end
      end
      PH_U, PH_HI_U: begin
        if (is_hex) begin
          acc_nxt = v_full;
          if (k_r != 2'd3) begin
            case (k_r)
              2'd0:    dig0_nxt = in_byte;
              2'd1:    dig1_nxt = in_byte;
              default: dig2_nxt = in_byte;
            endcase
            if (in_last) begin
              t.pre_repl  = (ph_r == PH_HI_U);
              t.rep_len   = {1'b0, k_r} + 3'd2;
              t.tail_kind = TAIL_BYTE;
              t.tail_val  = {13'd0, in_byte};
              ph_nxt      = PH_PLAIN;
            end else begin
              k_nxt = k_r + 2'd1;
            end
          end else begin
            ph_nxt = PH_PLAIN;
            if (ph_r == PH_HI_U && v_lo) begin
              t.tail_kind = TAIL_CP;
              t.tail_val  = pair_cp;
            end else begin
              t.pre_repl  = (ph_r == PH_HI_U);
              t.tail_kind = TAIL_CP;
              if (v_hi) begin
                if (in_last) begin
                  t.tail_val = CP_REPL;
                end else begin
                  t.tail_kind = TAIL_NONE;
                  hi_nxt      = v_full;
                  ph_nxt      = PH_HI;
                end
              end else if (v_lo) begin
                t.tail_val = CP_REPL;
              end else begin
                t.tail_val = {5'd0, v_full};
              end
            end
          end
        end else begin
          t.pre_repl = (ph_r == PH_HI_U);
          t.rep_len  = {1'b0, k_r} + 3'd2;
          fresh      = 1'b1;
        end
      end
      PH_HI: begin
        if (in_byte == CH_BSLASH && !in_last) begin
          ph_nxt = PH_HI_BS;
        end else begin
          t.pre_repl = 1'b1;
          fresh      = 1'b1;
        end
      end
      default: ph_nxt = PH_PLAIN;
    endcase
    if (fresh) begin
      if (in_byte != CH_BSLASH || in_last) begin
        t.tail_kind = TAIL_BYTE;
        t.tail_val  = {13'd0, in_byte};
        ph_nxt      = PH_PLAIN;
      end else begin
        ph_nxt = PH_BS;
      end
    end
  end

  assign tok  = t;
  assign push = accept && (t.pre_repl || (t.rep_len != 3'd0) || (t.tail_kind != TAIL_NONE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= PH_PLAIN;
      k_r   <= 2'd0;
      acc_r <= 16'd0;
      hi_r  <= 16'd0;
    end else if (accept) begin
      ph_r  <= ph_nxt;
      k_r   <= k_nxt;
      acc_r <= acc_nxt;
      hi_r  <= hi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dig0_r <= dig0_nxt;
      dig1_r <= dig1_nxt;
      dig2_r <= dig2_nxt;
    end
  end

  `ASSERT_RST(a_last_flushes, clk, rst_n, (push && tok.last) |=> (ph_r == PH_PLAIN), "state held after last item")

endmodule

`default_nettype wire

### sv/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Short token FIFO between the parser and the byte emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module jsu_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  jsu_pkg::jsu_tok_t  push_tok,
  output logic               full,
  input  wire                pop,
  output logic               head_valid,
  output jsu_pkg::jsu_tok_t  head_tok
);
  import jsu_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  jsu_tok_t        slot_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r, count_nxt;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_tok   = slot_r[rd_ptr_r];

  always_comb begin
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_tok;
  end

  `ASSERT_NEVER(a_q_overfill, clk, rst_n, count_r > CW'(DEPTH), "queue count beyond depth")
  `ASSERT_RST(a_q_drain, clk, rst_n, (pop && !push) |=> (count_r == $past(count_r) - 1'b1), "pop lost")
  `ASSERT_NEVER(a_q_ptrs, clk, rst_n, (count_r == '0) && (wr_ptr_r != rd_ptr_r), "empty with ptr skew")

endmodule

`default_nettype wire

### sv/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Byte emitter: expands each token into its output bytes, one per cycle while out_ready allows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module jsu_back (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                head_valid,
  input  jsu_pkg::jsu_tok_t  head_tok,
  output logic               pop,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [7:0]         out_byte,
  output logic               out_last
);
  import jsu_pkg::*;

  function automatic logic [2:0] utf8_len(input logic [20:0] cp);
    if (cp < 21'h80)         return 3'd1;
    else if (cp < 21'h800)   return 3'd2;
    else if (cp < 21'h10000) return 3'd3;
    else                     return 3'd4;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                           input logic [1:0] pos);
    logic [7:0] b;
    case (len)
      3'd1: b = cp[7:0];
      3'd2: b = (pos == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
      3'd3: begin
        case (pos)
          2'd0:    b = {4'b1110, cp[15:12]};
          2'd1:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (pos)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] pre_n, rep_n, tail_n, tot_n, rep_pos, tail_pos;
  logic [2:0]       cp_len;
  logic [7:0]       byte_sel;
  logic             adv;
  logic             is_end;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_last_r;

  assign cp_len   = utf8_len(head_tok.tail_val);
  assign pre_n    = head_tok.pre_repl ? IDX_W'(3) : '0;
  assign rep_n    = IDX_W'(head_tok.rep_len);
  assign rep_pos  = idx_r - pre_n;
  assign tail_pos = rep_pos - rep_n;
  assign tot_n    = pre_n + rep_n + tail_n;
  assign is_end   = (idx_r == tot_n - 1'b1);

  always_comb begin
    case (head_tok.tail_kind)
      TAIL_BYTE: tail_n = IDX_W'(1);
      TAIL_CP:   tail_n = IDX_W'(cp_len);
      default:   tail_n = '0;
    endcase
  end

  always_comb begin
    if (idx_r < pre_n) begin
      case (idx_r[1:0])
        2'd0:    byte_sel = 8'hEF;
        2'd1:    byte_sel = 8'hBF;
        default: byte_sel = 8'hBD;
      endcase
    end else if (rep_pos < rep_n) begin
      case (rep_pos[2:0])
        3'd0:    byte_sel = CH_BSLASH;
        3'd1:    byte_sel = CH_U;
        3'd2:    byte_sel = head_tok.dig0;
        3'd3:    byte_sel = head_tok.dig1;
        default: byte_sel = head_tok.dig2;
      endcase
    end else if (head_tok.tail_kind == TAIL_CP) begin
      byte_sel = utf8_byte(head_tok.tail_val, cp_len, tail_pos[1:0]);
    end else begin
      byte_sel = head_tok.tail_val[7:0];
    end
  end

  assign adv     = !out_valid_r || out_ready;
  assign pop     = adv && head_valid && is_end;
  assign idx_nxt = (adv && head_valid) ? (is_end ? '0 : idx_r + 1'b1) : idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      if (adv) out_valid_r <= head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && head_valid) begin
      out_byte_r <= byte_sel;
      out_last_r <= head_tok.last && is_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

  `ASSERT_RST(a_mid_token, clk, rst_n, (idx_r != '0) |-> head_valid, "token left head mid-way")

endmodule

`default_nettype wire

### sv/json_string_unescape_top.sv
// ----------------------------------------------------------------------------
// json_string_unescape_top
// JSON string body unescaper with UTF-8 output for \u escapes.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one raw byte of the escaped string body per item; in_tlast on the
//           final byte of the string flushes every held byte.
//   out_* : unescaped bytes, out_tlast on the final byte of a flushed string.
//   An item whose byte completes a token passes through the token queue and
//   then the output register to out_tvalid. Plain bytes stream at one item
//   per cycle while out_tready is high. An item that resolves an escape
//   yields 1 to 9 bytes; the emitter drains one byte per cycle while
//   out_tready is high, and the input keeps flowing until the token queue
//   (QUEUE_DEPTH entries) fills. Bytes of an unfinished escape give no
//   output until resolved. Reset (rst_n low, synchronous) empties the queue
//   and returns the parser to plain text. When the receiver stalls, the
//   output register holds its byte, the queue fills, and in_tready then drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] in_byte
  input  wire         in_tlast,
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // [7:0] out_byte
  output logic        out_tlast
);
  import jsu_pkg::*;

  logic     push, q_full, pop, head_valid;
  jsu_tok_t push_tok, head_tok;

  jsu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .q_full   (q_full),
    .push     (push),
    .tok      (push_tok)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_tok   (push_tok),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_tok   (head_tok)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_tok   (head_tok),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

`default_nettype wire
